// ===== hdl/efsd_pkg.sv =====
package efsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int DATA_W      = 32;
    localparam int DUR_W       = 16;
    localparam int VAL_W       = 16;
    localparam int CFG_W       = 5;
    localparam int SIDX_W      = 5;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int WIDE_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFG_RESET   = (16 > MAX_SERVERS) ? MAX_SERVERS : 16;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic [VAL_W-1:0] job_value;
        logic             new_batch;
        logic             last_job;
    } in_word_t;

    typedef struct packed {
        logic [SIDX_W-1:0] server_index;
        logic [DATA_W-1:0] server_finish;
        logic [DATA_W-1:0] server_value_total;
        logic [DATA_W-1:0] makespan;
        logic              batch_done;
    } out_word_t;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] finish;
    } chain_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

endpackage

// ===== hdl/efsd_cell.sv =====
module efsd_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [efsd_pkg::IDX_W-1:0]    cell_id,
    input  logic [efsd_pkg::CNT_W-1:0]    server_limit,
    input  logic                          clear,
    input  logic                          wr_en,
    input  logic [efsd_pkg::DUR_W-1:0]    duration,
    input  logic [efsd_pkg::VAL_W-1:0]    job_value,
    input  efsd_pkg::chain_t              chain_in,
    output efsd_pkg::chain_t              chain_out,
    output logic [efsd_pkg::DATA_W-1:0]   finish,
    output logic [efsd_pkg::DATA_W-1:0]   value_total
);
    import efsd_pkg::*;

    logic [DATA_W-1:0] finish_reg, finish_next;
    logic [DATA_W-1:0] value_reg, value_next;
    chain_t            chain_reg, chain_next;
    logic [DATA_W:0]   finish_sum;
    logic [DATA_W:0]   value_sum;
    logic              own_active;
    logic              take;

    assign finish_sum = {1'b0, finish_reg} + (DATA_W+1)'(duration);
    assign value_sum  = {1'b0, value_reg} + (DATA_W+1)'(job_value);

    // clear or saturating update of this server
    always_comb
    begin
        finish_next = finish_reg;
        value_next  = value_reg;
        if (clear)
        begin
            finish_next = '0;
            value_next  = '0;
        end
        else if (wr_en)
        begin
            finish_next = finish_sum[DATA_W] ? '1 : finish_sum[DATA_W-1:0];
            value_next  = value_sum[DATA_W] ? '1 : value_sum[DATA_W-1:0];
        end
    end

    // strict less keeps the lower server on a tie
    assign own_active = CNT_W'(cell_id) < server_limit;
    assign take = own_active && (!chain_in.found || (finish_reg < chain_in.finish));

    always_comb
    begin
        chain_next = chain_in;
        if (take)
        begin
            chain_next.found  = 1'b1;
            chain_next.idx    = cell_id;
            chain_next.finish = finish_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finish_reg <= '0;
            value_reg  <= '0;
            chain_reg  <= '0;
        end
        else
        begin
            finish_reg <= finish_next;
            value_reg  <= value_next;
            chain_reg  <= chain_next;
        end
    end

    assign chain_out   = chain_reg;
    assign finish      = finish_reg;
    assign value_total = value_reg;

endmodule

// ===== hdl/earliest_free_server_dispatch_core.sv =====
// Greedy list scheduler: each accepted word is a job that goes to the next unused server
// while fewer than server_count servers have been used in the batch, and otherwise to the
// server with the earliest finish time (lowest number on a tie). One result word comes back
// per job. A fresh-server job passes the update and done states into the output register;
// a searching job waits in the scan state, set by the row of server cells through which
// the running best finish time moves one cell per cycle. A new job is taken once the
// previous one has reached the output register, even if that result has not been taken
// yet. server_count is to be written through cfg_wr_en/cfg_wr_data while the block is
// idle (unchecked by the block); 0 acts as 1, values above MAX_SERVERS as MAX_SERVERS.
module earliest_free_server_dispatch_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [efsd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  efsd_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output efsd_pkg::out_word_t         out_data
);
    import efsd_pkg::*;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   count_cfg_reg;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [DATA_W-1:0]  longest_reg, longest_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [DUR_W-1:0]   dur_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               last_reg;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_reg;

    logic [WIDE_W-1:0]  count_wide;
    logic [CNT_W-1:0]   n_active;
    logic [CNT_W-1:0]   filled_eff;
    logic               in_acc;
    logic               fill_path;
    logic               out_load;
    logic               clear_all;
    logic [IDX_W:0]     pick_plus;
    logic [DATA_W-1:0]  sel_finish;
    logic [DATA_W-1:0]  sel_value;

    chain_t             chain [0:MAX_SERVERS];
    logic [DATA_W-1:0]  cell_finish [MAX_SERVERS];
    logic [DATA_W-1:0]  cell_value [MAX_SERVERS];

    assign count_wide = WIDE_W'(count_cfg_reg);

    always_comb
    begin
        priority if (count_wide == '0)
            n_active = CNT_W'(1);
        else if (count_wide > WIDE_W'(MAX_SERVERS))
            n_active = CNT_W'(MAX_SERVERS);
        else
            n_active = CNT_W'(count_wide);
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign clear_all  = in_acc && in_data.new_batch;
    assign filled_eff = in_data.new_batch ? '0 : filled_reg;
    assign fill_path  = filled_eff < n_active;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_SERVERS; i++)
    begin : g_cell
        efsd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_id      (IDX_W'(i)),
            .server_limit (n_active),
            .clear        (clear_all),
            .wr_en        ((state_reg == S_UPDATE) && (pick_reg == IDX_W'(i))),
            .duration     (dur_reg),
            .job_value    (val_reg),
            .chain_in     (chain[i]),
            .chain_out    (chain[i+1]),
            .finish       (cell_finish[i]),
            .value_total  (cell_value[i])
        );
    end

    assign sel_finish = cell_finish[pick_reg];
    assign sel_value  = cell_value[pick_reg];
    assign pick_plus  = {1'b0, pick_reg} + (IDX_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        longest_next   = longest_reg;
        scan_cnt_next  = scan_cnt_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    scan_cnt_next = '0;
                    if (in_data.new_batch)
                        longest_next = '0;
                    if (fill_path)
                    begin
                        pick_next   = IDX_W'(filled_eff);
                        filled_next = filled_eff + CNT_W'(1);
                        state_next  = S_UPDATE;
                    end
                    else
                    begin
                        filled_next = filled_eff;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(MAX_SERVERS))
                begin
                    pick_next  = chain[MAX_SERVERS].idx;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    if (sel_finish > longest_reg)
                        longest_next = sel_finish;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_cfg_reg <= CFG_W'(CFG_RESET);
            filled_reg    <= '0;
            longest_reg   <= '0;
            scan_cnt_reg  <= '0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            longest_reg   <= longest_next;
            scan_cnt_reg  <= scan_cnt_next;
            pick_reg      <= pick_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                count_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dur_reg  <= in_data.duration;
            val_reg  <= in_data.job_value;
            last_reg <= in_data.last_job;
        end
        if (out_load)
        begin
            out_reg.server_index       <= SIDX_W'(pick_plus);
            out_reg.server_finish      <= sel_finish;
            out_reg.server_value_total <= sel_value;
            out_reg.makespan           <= (sel_finish > longest_reg) ? sel_finish : longest_reg;
            out_reg.batch_done         <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/efsd_checker.sv =====
module efsd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_wr_en,
    input logic [efsd_pkg::CFG_W-1:0]  cfg_wr_data,
    input logic                        in_valid,
    input logic                        in_ready,
    input efsd_pkg::in_word_t          in_data,
    input logic                        out_valid,
    input logic                        out_ready,
    input efsd_pkg::out_word_t         out_data
);
    import efsd_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // makespan never below the finish time just reported
    a_makespan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.makespan >= out_data.server_finish)
        else $error("makespan below server finish");

    // server numbers start at one
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.server_index != '0)
        else $error("server index zero");

    // a job keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");

endmodule

bind earliest_free_server_dispatch_core efsd_checker u_efsd_checker (.*);
